// ===== design/lkvc_pkg.sv =====
// Package for the LRU key/value cache: controller states and the
// command/status structs between controller and datapath. No dependencies.
package lkvc_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_TRIM,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;      // capture a request beat
      logic lookup;    // compare, update rank, write entry
      logic trim;      // evict one least recent entry
      logic clear_ev;  // clear evicted flag
   } cmd_type;

   typedef struct packed {
      logic ignored;   // put without valid key
      logic plain_hit; // get hit without refetch, which never evicts
      logic over;      // count above limit
   } status_type;

endpackage

// ===== design/lkvc_datapath.sv =====
// Datapath of the LRU key/value cache: entry registers, compare-all,
// rank update, one-per-cycle eviction. Depends on lkvc_pkg.
module lkvc_datapath #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lkvc_pkg::cmd_type        cmd,
   output lkvc_pkg::status_type     status,
   input  logic                     csr_we,
   input  logic [4:0]               csr_wdata,
   input  logic [KEY_BITS+VALUE_BITS+2:0] req_fields,
   output logic                     res_hit,
   output logic [63:0]              res_value,
   output logic                     res_evicted
);
   localparam int RW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [KEY_BITS-1:0]   key_ff [DEPTH];
   logic [VALUE_BITS-1:0] val_ff [DEPTH];
   logic [DEPTH-1:0]      valid_ff, valid_in;
   logic [RW-1:0]         rank_ff [DEPTH];
   logic [RW-1:0]         rank_in [DEPTH];
   logic [CW-1:0]         count_ff, count_in;
   logic [4:0]            max_ff;
   logic [KEY_BITS+VALUE_BITS+2:0] req_ff;
   logic                  hit_ff, hit_in, ev_ff, ev_in;
   logic [VALUE_BITS-1:0] out_ff, out_in;

   logic                  r_put, r_kv, r_ref;
   logic [KEY_BITS-1:0]   r_key;
   logic [VALUE_BITS-1:0] r_fill;
   logic [DEPTH-1:0]      match;
   logic                  found;
   logic [RW-1:0]         fidx, slot, oldest;
   logic                  have_free;
   logic [CW-1:0]         limit;

   assign r_fill = req_ff[VALUE_BITS-1:0];
   assign r_ref  = req_ff[VALUE_BITS];
   assign r_kv   = req_ff[VALUE_BITS+1];
   assign r_key  = req_ff[VALUE_BITS+KEY_BITS+1:VALUE_BITS+2];
   assign r_put  = req_ff[VALUE_BITS+KEY_BITS+2];

   always_comb begin
      if (max_ff == 5'd0) limit = CW'(1);
      else if ({{(CW+5){1'b0}}, max_ff} > (CW+10)'(DEPTH)) limit = CW'(DEPTH);
      else limit = CW'(max_ff);
   end

   always_comb begin
      found = 1'b0;
      fidx = '0;
      have_free = 1'b0;
      slot = '0;
      oldest = '0;
      for (int j = DEPTH - 1; j >= 0; j--) begin
         match[j] = valid_ff[j] && (key_ff[j] == r_key);
         if (match[j]) begin
            found = 1'b1;
            fidx = RW'(j);
         end
         if (!valid_ff[j]) begin
            have_free = 1'b1;
            slot = RW'(j);
         end
         if (valid_ff[j] && rank_ff[j] == RW'(count_ff - CW'(1))) oldest = RW'(j);
      end
   end

   assign status.ignored   = r_put && !r_kv;
   assign status.plain_hit = !r_put && !r_ref && found;
   assign status.over      = count_ff > limit;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      hit_in   = hit_ff;
      ev_in    = ev_ff;
      out_in   = out_ff;
      for (int j = 0; j < DEPTH; j++) rank_in[j] = rank_ff[j];
      if (cmd.clear_ev) ev_in = 1'b0;
      if (cmd.lookup) begin
         hit_in = found && !status.ignored;
         if (status.ignored) begin
            out_in = '0;
         end else if (found) begin
            for (int j = 0; j < DEPTH; j++)
               if (valid_ff[j] && rank_ff[j] < rank_ff[fidx]) rank_in[j] = rank_ff[j] + RW'(1);
            rank_in[fidx] = '0;
            out_in = (!r_put && !r_ref) ? val_ff[fidx] : r_fill;
         end else if (!have_free) begin
            // Full: the oldest slot is reused, every other entry ages by one.
            for (int j = 0; j < DEPTH; j++) rank_in[j] = rank_ff[j] + RW'(1);
            rank_in[oldest] = '0;
            ev_in  = 1'b1;
            out_in = r_fill;
         end else begin
            for (int j = 0; j < DEPTH; j++)
               if (valid_ff[j]) rank_in[j] = rank_ff[j] + RW'(1);
            rank_in[slot]  = '0;
            valid_in[slot] = 1'b1;
            count_in = count_ff + CW'(1);
            out_in   = r_fill;
         end
      end
      if (cmd.trim) begin
         valid_in[oldest] = 1'b0;
         rank_in[oldest]  = '0;
         count_in = count_ff - CW'(1);
         ev_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         max_ff   <= 5'd16;
         for (int j = 0; j < DEPTH; j++) rank_ff[j] <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int j = 0; j < DEPTH; j++) rank_ff[j] <= rank_in[j];
         if (csr_we) max_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      ev_ff  <= ev_in;
      out_ff <= out_in;
      if (cmd.load) req_ff <= req_fields;
      if (cmd.lookup && !status.ignored) begin
         if (found) begin
            if (r_put || r_ref) val_ff[fidx] <= r_fill;
         end else if (!have_free) begin
            key_ff[oldest] <= r_key;
            val_ff[oldest] <= r_fill;
         end else begin
            key_ff[slot] <= r_key;
            val_ff[slot] <= r_fill;
         end
      end
   end

   assign res_hit     = hit_ff;
   assign res_evicted = ev_ff;
   assign res_value   = 64'(out_ff);

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff)) else $error("count mismatch");
   a_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match)) else $error("duplicate key");
   a_trim: assert property (@(posedge clock) disable iff (reset)
      cmd.trim |-> count_ff != '0) else $error("trim on empty");
`endif
endmodule

// ===== design/lkvc_ctrl.sv =====
// Controller of the LRU key/value cache: sequences load, lookup, trim
// and result delivery. Depends on lkvc_pkg.
module lkvc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output lkvc_pkg::cmd_type     cmd,
   input  lkvc_pkg::status_type  status
);
   lkvc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lkvc_pkg::ST_IDLE:   if (req_tvalid) state_in = lkvc_pkg::ST_LOOKUP;
         lkvc_pkg::ST_LOOKUP: state_in = (status.ignored || status.plain_hit)
                                         ? lkvc_pkg::ST_RESULT : lkvc_pkg::ST_TRIM;
         lkvc_pkg::ST_TRIM:   if (!status.over) state_in = lkvc_pkg::ST_RESULT;
         lkvc_pkg::ST_RESULT: if (rsp_tready) state_in = lkvc_pkg::ST_IDLE;
         default:             state_in = lkvc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = state_ff == lkvc_pkg::ST_IDLE;
      rsp_tvalid   = state_ff == lkvc_pkg::ST_RESULT;
      cmd.load     = req_tready && req_tvalid;
      cmd.clear_ev = cmd.load;
      cmd.lookup   = state_ff == lkvc_pkg::ST_LOOKUP;
      cmd.trim     = state_ff == lkvc_pkg::ST_TRIM && status.over;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= lkvc_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_one: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("busy overlap");
   a_look: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.lookup) else $error("lookup missing");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
`endif
endmodule

// ===== design/lru_key_value_cache_core.sv =====
// LRU key/value cache top level: controller plus datapath.
// A beat that writes the store passes through the lookup and trim states, trimming
// least recent entries while over the limit; an ignored put or a plain get hit skips trim.
// A new request is accepted only after the previous response has been taken.
// Synchronous reset empties the cache, max_entries 16.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
module lru_key_value_cache_core #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // op, key[64], key_valid, refetch, fill_value[64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // hit, value[64], evicted
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata
);
   lkvc_pkg::cmd_type    cmd;
   lkvc_pkg::status_type status;
   logic                 hit, ev;
   logic [63:0]          value;
   logic [KEY_BITS+VALUE_BITS+2:0] fields;

   assign fields = {req_tdata[0], req_tdata[KEY_BITS:1], req_tdata[65], req_tdata[66],
                    req_tdata[67 +: VALUE_BITS]};

   lkvc_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .status
   );

   lkvc_datapath #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock, .reset, .cmd, .status, .csr_we, .csr_wdata,
      .req_fields(fields), .res_hit(hit), .res_value(value), .res_evicted(ev)
   );

   assign rsp_tdata = {6'd0, ev, value, hit};
endmodule

// ===== verif/lkvc_checker.sv =====
// Checker for the LRU key/value cache: watches request and response beats,
// predicts each response with its own LRU store model and compares fields.
// Depends only on the port layout of lru_key_value_cache_core.
`timescale 1ns / 1ps

module lkvc_checker #(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata,
   output int           mismatches,
   output int           pending,
   output int           responses,
   output int           hits_seen,
   output int           evictions_seen
);

   typedef struct packed {
      logic        hit;
      logic [63:0] value;
      logic        evicted;
   } lookup_result_type;

   logic [63:0] line_key [DEPTH];
   logic [63:0] line_value [DEPTH];
   logic        line_valid [DEPTH];
   int          line_age [DEPTH];
   int          line_count;
   logic [4:0]  max_lines;

   lookup_result_type expected_results[$];

   assign pending = expected_results.size();

   function automatic int capacity();
      if (max_lines == 0) return 1;
      if (max_lines > DEPTH) return DEPTH;
      return max_lines;
   endfunction

   function automatic void drop_oldest();
      int victim;
      victim = -1;
      for (int j = 0; j < DEPTH; j++)
         if (line_valid[j] && (victim < 0 || line_age[j] > line_age[victim])) victim = j;
      if (victim >= 0) begin
         line_valid[victim] = 1'b0;
         line_age[victim] = 0;
         if (line_count > 0) line_count--;
      end
   endfunction

   function automatic void touch(int slot);
      int prior;
      prior = line_age[slot];
      for (int j = 0; j < DEPTH; j++)
         if (line_valid[j] && line_age[j] < prior) line_age[j]++;
      line_age[slot] = 0;
   endfunction

   function automatic lookup_result_type predict_lookup(logic [135:0] beat);
      lookup_result_type r;
      logic        is_put, key_ok, refetch;
      logic [63:0] key, fill;
      int          found, slot;
      is_put  = beat[0];
      key     = beat[64:1];
      key_ok  = beat[65];
      refetch = beat[66];
      fill    = beat[130:67];
      r       = '0;
      found   = -1;
      slot    = -1;
      if (is_put && !key_ok) return r;
      for (int j = 0; j < DEPTH; j++)
         if (found < 0 && line_valid[j] && line_key[j] == key) found = j;
      r.hit = (found >= 0);
      if (!is_put && r.hit && !refetch) begin
         touch(found);
         r.value = line_value[found];
         return r;
      end
      if (r.hit) begin
         touch(found);
         line_value[found] = fill;
      end else begin
         if (line_count >= DEPTH) begin
            drop_oldest();
            r.evicted = 1'b1;
         end
         for (int j = 0; j < DEPTH; j++)
            if (slot < 0 && !line_valid[j]) slot = j;
         for (int j = 0; j < DEPTH; j++)
            if (line_valid[j]) line_age[j]++;
         line_valid[slot] = 1'b1;
         line_key[slot] = key;
         line_value[slot] = fill;
         line_age[slot] = 0;
         line_count++;
      end
      while (line_count > capacity()) begin
         drop_oldest();
         r.evicted = 1'b1;
      end
      r.value = fill;
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want, got;
      if (reset) begin
         for (int j = 0; j < DEPTH; j++) begin
            line_valid[j] = 1'b0;
            line_age[j] = 0;
            line_key[j] = '0;
            line_value[j] = '0;
         end
         line_count = 0;
         max_lines = 5'd16;
         expected_results.delete();
         mismatches = 0;
         responses = 0;
         hits_seen = 0;
         evictions_seen = 0;
      end else begin
         if (csr_we) max_lines = csr_wdata;
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_lookup(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.hit = rsp_tdata[0];
            got.value = rsp_tdata[64:1];
            got.evicted = rsp_tdata[65];
            responses++;
            if (expected_results.size() == 0) begin
               $error("response beat with no request waiting: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (got.hit) hits_seen++;
               if (got.evicted) evictions_seen++;
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, got.hit);
                  mismatches++;
               end
               if (got.value !== want.value) begin
                  $error("value: expected %h, got %h", want.value, got.value);
                  mismatches++;
               end
               if (got.evicted !== want.evicted) begin
                  $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                  mismatches++;
               end
            end
         end
      end
   end

endmodule

// ===== verif/tb_top.sv =====
// Top of the LRU key/value cache testbench: clock, reset, request and
// configuration stimulus, response back-pressure and the verdict.
// Depends on lru_key_value_cache_core and lkvc_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;
   localparam int   CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [4:0]   csr_wdata = '0;
   int           mismatches, pending, responses, hits_seen, evictions_seen;
   int           cycles = 0;
   bit           long_hold = 1'b0;
   bit           stall_on = 1'b0;
   logic [63:0]  key_pool [8];

   always #4 clock = ~clock;

   lru_key_value_cache_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   lkvc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending(pending), .responses(responses),
      .hits_seen(hits_seen), .evictions_seen(evictions_seen)
   );

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 2);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            for (int c = 0; c < 200; c++) @(posedge clock);
            long_hold = 1'b0;
         end else if (stall_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            hold = gap_length();
            for (int c = 0; c < hold; c++) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Every beat starts only after the previous one was accepted, with a random gap if with_gaps.
   task automatic send_beat(logic op, logic [63:0] key, logic key_ok, logic refetch,
                            logic [63:0] fill, bit with_gaps);
      int gap;
      gap = with_gaps ? gap_length() : 0;
      for (int c = 0; c <= gap; c++) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, fill, refetch, key_ok, key, op};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_limit(logic [4:0] limit);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      logic [63:0] key;
      logic        op;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, 7)] +
                                              $urandom_range(0, 15);
         else key = {$urandom, $urandom};
         op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
         send_beat(op, key, $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0,
                   {$urandom, $urandom}, 1'b1);
      end
   endtask

   initial begin
      for (int j = 0; j < 8; j++) key_pool[j] = {$urandom, $urandom} & ~64'hff;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every operation, ignored put, refetch, full store.
      send_beat(OP_GET, 64'h0, 1'b0, 1'b0, 64'hffff_ffff_ffff_ffff, 1'b0);
      send_beat(OP_GET, 64'h0, 1'b1, 1'b0, 64'h1, 1'b0);
      send_beat(OP_GET, 64'h0, 1'b1, 1'b1, 64'h2, 1'b0);
      send_beat(OP_PUT, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 64'h0, 1'b0);
      send_beat(OP_PUT, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 64'h5, 1'b0);
      send_beat(OP_PUT, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 64'haaaa_5555_aaaa_5555, 1'b0);
      send_beat(OP_GET, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 64'h3, 1'b0);
      for (int j = 1; j <= 17; j++)
         send_beat(OP_PUT, 64'h1000 + j, 1'b1, 1'b0, 64'h5555_aaaa_0000_0000 + j, 1'b0);
      send_beat(OP_GET, 64'h1001, 1'b0, 1'b0, 64'h7, 1'b0);

      // Lowered limit takes effect only on the next write; a plain hit keeps all.
      write_limit(5'd3);
      send_beat(OP_GET, 64'h1011, 1'b1, 1'b0, 64'h9, 1'b0);
      send_beat(OP_GET, 64'h1010, 1'b1, 1'b1, 64'ha, 1'b0);
      write_limit(5'd0);
      send_beat(OP_PUT, 64'h2000, 1'b1, 1'b0, 64'hb, 1'b0);
      send_beat(OP_GET, 64'h2000, 1'b1, 1'b0, 64'hc, 1'b0);

      stall_on = 1'b1;
      write_limit(5'd31);
      random_phase(110);
      write_limit(5'd4);
      random_phase(110);
      write_limit(5'd1);
      random_phase(80);
      write_limit(5'd16);
      long_hold = 1'b1;
      random_phase(120);
      write_limit(5'($urandom_range(2, 15)));
      random_phase(110);

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent about 555 requests over limits 16, 3, 0, 31, 4, 1 and random;");
      $display("%0d responses, %0d hits, %0d with evictions.",
               responses, hits_seen, evictions_seen);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
design/lkvc_pkg.sv
design/lkvc_datapath.sv
design/lkvc_ctrl.sv
design/lru_key_value_cache_core.sv
verif/lkvc_checker.sv
verif/tb_top.sv
